// File: hw/rtl/pltf_pkg.sv
// ----------------------------------------------------------------------------
// pltf_pkg: shared types and constants
// Action codes and the payload types used by the channel interfaces.
// ----------------------------------------------------------------------------
package pltf_pkg;

    // table depth; point_index and the count registers are sized for it
    localparam int MAX_POINTS = 8;

    typedef enum logic [1:0] {
        ACT_LOAD_COLOR   = 2'd0,
        ACT_LOAD_OPACITY = 2'd1,
        ACT_EVALUATE     = 2'd2,
        ACT_NONE         = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  point_index;
        logic [15:0] point_position;
        logic [15:0] value_red;
        logic [15:0] value_green;
        logic [15:0] value_blue;
        logic [15:0] value_opacity;
        logic [15:0] sample_position;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_word;

    localparam logic [3:0] REG_COLOR_COUNT   = 4'd0;
    localparam logic [3:0] REG_OPACITY_COUNT = 4'd1;

endpackage

// File: hw/rtl/pltf_in_if.sv
// ----------------------------------------------------------------------------
// pltf_in_if: input word channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface pltf_in_if;
    logic               valid;
    logic               ready;
    pltf_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/pltf_out_if.sv
// ----------------------------------------------------------------------------
// pltf_out_if: result word channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pltf_out_if;
    logic                valid;
    logic                ready;
    pltf_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/piecewise_linear_transfer_function_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_transfer_function_unit: color/opacity lookup with lerp
// Two control point tables in synchronous RAM, scan plus serial divide.
// ----------------------------------------------------------------------------
// Usage: words arrive on i_in (valid/ready). A load word writes one point to
// the color or opacity table. An evaluate word scans both tables (one RAM
// read per point, registered), then interpolates red, green, blue and alpha
// one after another, each by a 32-by-16 restoring divide, then scales to a
// byte. One result word leaves on o_out. i_in.ready returns in the same cycle
// that o_out goes valid. One word is in flight at a time.
// The result sits in an output register; while o_out stalls the block may
// already accept the next word and only waits to deliver its own result.
// Reset (i_rst_n low, synchronous) clears control state and starts a clearing
// pass over all MAX_POINTS entries that writes the default ramps into both
// tables; no word is accepted during it. Counts reset to 5 and 2; the user
// must write them over the APB port only while idle, as the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module piecewise_linear_transfer_function_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pltf_in_if.sink     i_in,
    pltf_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int MAX_POINTS = pltf_pkg::MAX_POINTS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_SCAN_WAIT, S_SEL, S_SEL_WAIT,
        S_SETUP, S_DIV, S_NEXT, S_DONE
    } t_state;

    // memories: color {pos,r,g,b}, opacity {pos,a}
    logic [63:0] r_cmem [MAX_POINTS];
    logic [31:0] r_omem [MAX_POINTS];
    logic [63:0] r_crd;
    logic [31:0] r_ord;
    logic [AW-1:0] n_raddr;
    logic          n_we_c, n_we_o;
    logic [AW-1:0] n_waddr;
    logic [63:0]   n_wc;
    logic [31:0]   n_wo;

    // configuration
    localparam logic REG0 = pltf_pkg::REG_COLOR_COUNT[0];
    logic [3:0] r_ccnt, r_ocnt;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[2])
            REG0:    prdata = {28'd0, r_ccnt};
            default: prdata = {28'd0, r_ocnt};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= 4'd5;
            r_ocnt <= 4'd2;
        end else if (cfg_wr && paddr[1:0] == 2'd0) begin
            if (paddr[2] == pltf_pkg::REG_OPACITY_COUNT[0]) r_ocnt <= pwdata[3:0];
            else r_ccnt <= pwdata[3:0];
        end
    end

    // clamped counts
    logic [CW-1:0] ccl, ocl;
    assign ccl = (r_ccnt > 4'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_ccnt);
    assign ocl = (r_ocnt > 4'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_ocnt);

    t_state        r_state;
    logic [CW-1:0] r_idx;
    logic [15:0]   r_p;
    logic          r_tab;      // 0 color, 1 opacity
    logic [AW-1:0] r_k;
    logic          r_found;    // first i with p <= pos[i] seen
    logic          r_interp;
    logic [15:0]   r_first_pos;
    logic [15:0]   r_last_pos;
    logic [1:0]    r_ch;
    logic [63:0]   r_lo_c, r_hi_c;
    logic [31:0]   r_lo_o, r_hi_o;
    logic [31:0]   r_rem_num;  // dividend shifting out
    logic [16:0]   r_rem;
    logic [15:0]   r_d;
    logic [31:0]   r_q;
    logic [5:0]    r_cnt;
    logic [15:0]   r_val [4];
    logic          r_ovalid;
    pltf_pkg::t_out_word r_odata;

    logic in_fire, out_fire;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // default table contents for the clearing pass
    function automatic logic [63:0] cdef(input logic [CW-1:0] i);
        case (i)
            CW'(0):  cdef = {16'd0,     16'd0,     16'd0,     16'd65535};
            CW'(1):  cdef = {16'd16384, 16'd0,     16'd65535, 16'd65535};
            CW'(2):  cdef = {16'd32768, 16'd0,     16'd65535, 16'd0};
            CW'(3):  cdef = {16'd49151, 16'd65535, 16'd65535, 16'd0};
            CW'(4):  cdef = {16'd65535, 16'd65535, 16'd0,     16'd0};
            default: cdef = 64'd0;
        endcase
    endfunction

    // current table entry position and count
    logic [15:0]   rd_pos;
    logic [CW-1:0] cur_cnt;
    assign rd_pos  = r_tab ? r_ord[31:16] : r_crd[63:48];
    assign cur_cnt = r_tab ? ocl : ccl;

    // interpolation operands for the current channel
    logic [15:0] lo_pos, hi_pos, lo_v, hi_v;
    always_comb begin
        lo_pos = r_tab ? r_lo_o[31:16] : r_lo_c[63:48];
        hi_pos = r_tab ? r_hi_o[31:16] : r_hi_c[63:48];
        case (r_ch)
            2'd0:    begin lo_v = r_lo_c[47:32]; hi_v = r_hi_c[47:32]; end
            2'd1:    begin lo_v = r_lo_c[31:16]; hi_v = r_hi_c[31:16]; end
            2'd2:    begin lo_v = r_lo_c[15:0];  hi_v = r_hi_c[15:0];  end
            default: begin lo_v = r_lo_o[15:0];  hi_v = r_hi_o[15:0];  end
        endcase
    end
    logic [15:0] sp_d, sp_n;
    assign sp_d = (hi_pos > lo_pos) ? hi_pos - lo_pos : 16'd1;
    always_comb begin
        sp_n = (r_p > lo_pos) ? r_p - lo_pos : 16'd0;
        if (sp_n > sp_d) sp_n = sp_d;
    end
    // weighted sum: products registered first, then summed
    logic [31:0] r_pa, r_pb;
    logic        r_mulph;

    // restoring divide step
    logic [16:0] rem_sh;
    logic        ge;
    assign rem_sh = {r_rem[15:0], r_rem_num[31]};
    assign ge     = rem_sh >= {1'b0, r_d};

    // byte scaling: floor(v/257) = (v*255 + 255) >> 16 fits for 16-bit v
    function automatic logic [7:0] to_byte(input logic [15:0] v);
        logic [25:0] t;
        t = 26'(v) * 26'd255 + 26'd255;
        to_byte = t[23:16];
    endfunction

    always_comb begin
        n_raddr = r_idx[AW-1:0];
        // slot fetch: hi entry k first, then lo entry k-1
        if (r_state == S_SEL_WAIT) n_raddr = (r_idx == '0) ? r_k : r_k - 1'b1;
        n_we_c = 1'b0; n_we_o = 1'b0;
        n_waddr = i_in.data.point_index[AW-1:0];
        n_wc = {i_in.data.point_position, i_in.data.value_red,
                i_in.data.value_green, i_in.data.value_blue};
        n_wo = {i_in.data.point_position, i_in.data.value_opacity};
        if (r_state == S_INIT) begin
            n_we_c = 1'b1; n_we_o = 1'b1;
            n_waddr = r_idx[AW-1:0];
            n_wc = cdef(r_idx);
            n_wo = (r_idx == CW'(1)) ? 32'hFFFF_FFFF : 32'd0;
        end else if (in_fire && 32'(i_in.data.point_index) < MAX_POINTS) begin
            n_we_c = (i_in.data.action == pltf_pkg::ACT_LOAD_COLOR);
            n_we_o = (i_in.data.action == pltf_pkg::ACT_LOAD_OPACITY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we_c) r_cmem[n_waddr] <= n_wc;
        if (n_we_o) r_omem[n_waddr] <= n_wo;
        r_crd <= r_cmem[n_raddr];
        r_ord <= r_omem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_fire && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CW'(MAX_POINTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_idx <= '0;
                    if (in_fire && i_in.data.action == pltf_pkg::ACT_EVALUATE) begin
                        r_p   <= i_in.data.sample_position;
                        r_tab <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // address r_idx presented; data next cycle
                    r_found <= 1'b0;
                    r_k     <= '0;
                    if (cur_cnt == '0) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_SCAN_WAIT;
                        r_idx   <= r_idx + 1'b1;
                    end
                end
                S_SCAN_WAIT: begin
                    // rd_pos belongs to entry r_idx-1
                    if (r_idx == CW'(1)) r_first_pos <= rd_pos;
                    if (!r_found && r_p <= rd_pos) begin
                        r_found <= 1'b1;
                        r_k <= AW'(r_idx - 1'b1);
                    end
                    if (r_idx == cur_cnt) begin
                        r_last_pos <= rd_pos;
                        r_state <= S_SEL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SEL: begin
                    // r_last_pos is last entry; decide slot
                    if (r_p <= r_first_pos) begin
                        r_k <= '0; r_interp <= 1'b0;
                    end else if (r_p >= r_last_pos || !r_found) begin
                        r_k <= AW'(cur_cnt - 1'b1); r_interp <= 1'b0;
                    end else begin
                        r_interp <= 1'b1;
                    end
                    r_idx <= '0;
                    r_state <= S_SEL_WAIT;
                end
                S_SEL_WAIT: begin
                    // read hi entry k then lo entry k-1
                    if (r_idx == '0) begin
                        r_idx <= CW'(1);
                    end else if (r_idx == CW'(1)) begin
                        if (r_tab) r_hi_o <= r_ord; else r_hi_c <= r_crd;
                        r_idx <= CW'(2);
                    end else begin
                        if (r_tab) r_lo_o <= r_ord; else r_lo_c <= r_crd;
                        r_ch <= r_tab ? 2'd3 : 2'd0;
                        r_mulph <= 1'b0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    if (!r_interp) begin
                        r_val[r_ch] <= hi_v;
                        r_state <= S_NEXT;
                    end else if (!r_mulph) begin
                        r_pa <= 32'(lo_v) * 32'(sp_d - sp_n);
                        r_pb <= 32'(hi_v) * 32'(sp_n);
                        r_mulph <= 1'b1;
                    end else begin
                        r_rem_num <= r_pa + r_pb;
                        r_d   <= sp_d;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= ge ? rem_sh - {1'b0, r_d} : rem_sh;
                    r_rem_num <= {r_rem_num[30:0], 1'b0};
                    r_q       <= {r_q[30:0], ge};
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        r_val[r_ch] <= {r_q[14:0], ge};
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_idx <= '0;
                    r_mulph <= 1'b0;
                    if (!r_tab && r_interp && r_ch != 2'd2 && cur_cnt != '0) begin
                        r_ch <= r_ch + 1'b1;
                        r_state <= S_SETUP;
                    end else if (!r_tab) begin
                        if (cur_cnt == '0) begin
                            r_val[0] <= '0; r_val[1] <= '0; r_val[2] <= '0;
                        end else if (!r_interp) begin
                            r_val[0] <= r_hi_c[47:32];
                            r_val[1] <= r_hi_c[31:16];
                            r_val[2] <= r_hi_c[15:0];
                        end
                        r_tab <= 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        if (cur_cnt == '0) r_val[3] <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || out_fire) begin
                        r_odata.out_red   <= to_byte(r_val[0]);
                        r_odata.out_green <= to_byte(r_val[1]);
                        r_odata.out_blue  <= to_byte(r_val[2]);
                        r_odata.out_alpha <= to_byte(r_val[3]);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // read address k / k-1 during slot fetch
    // (r_idx drives the RAM in scan; during fetch override)
    logic unused_ok;
    assign unused_ok = &{pwdata[31:4], paddr};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(o_out.data)) else $error("result changed");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != 6'd31) |=> (r_state == S_DIV))
        else $error("divide cut short");
endmodule

// File: tb/pltf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pltf_checker: transfer function predictor and result checker
// Watches the input and result channels and the APB writes, keeps its own
// copy of both control point tables and counts, and compares every result
// word with the oldest predicted one.
// ----------------------------------------------------------------------------
module pltf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pltf_in_if.sink     i_mon_in,
    pltf_out_if.sink    i_mon_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    localparam int NPTS = pltf_pkg::MAX_POINTS;

    logic [15:0] col_pos [NPTS];
    logic [15:0] col_val [NPTS][3];
    logic [15:0] opa_pos [NPTS];
    logic [15:0] opa_val [NPTS];
    logic [3:0]  col_cnt;
    logic [3:0]  opa_cnt;
    pltf_pkg::t_out_word expected_colors [$];

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    function automatic logic [15:0] lerp(input logic [15:0] lp, input logic [15:0] hp,
                                         input logic [15:0] lv, input logic [15:0] hv,
                                         input logic [15:0] p);
        longint d;
        longint n;
        d = (hp > lp) ? longint'(hp - lp) : 1;
        n = (p > lp) ? longint'(p - lp) : 0;
        if (n > d) n = d;
        return 16'((longint'(lv) * (d - n) + longint'(hv) * n) / d);
    endfunction

    // Returns slot and whether it interpolates from the slot below.
    function automatic int find_slot(input logic [15:0] pos [NPTS], input int cnt,
                                     input logic [15:0] p, output bit interp);
        interp = 0;
        if (p <= pos[0]) return 0;
        if (p >= pos[cnt-1]) return cnt - 1;
        for (int i = 1; i < cnt; i++)
            if (p <= pos[i]) begin
                interp = 1;
                return i;
            end
        return cnt - 1;
    endfunction

    function automatic pltf_pkg::t_out_word shade(input logic [15:0] p);
        pltf_pkg::t_out_word r;
        logic [15:0] v;
        int cnt, k;
        bit ip;
        r = '0;
        cnt = (col_cnt > NPTS) ? NPTS : int'(col_cnt);
        if (cnt > 0) begin
            k = find_slot(col_pos, cnt, p, ip);
            for (int c = 0; c < 3; c++) begin
                v = ip ? lerp(col_pos[k-1], col_pos[k], col_val[k-1][c], col_val[k][c], p)
                       : col_val[k][c];
                case (c)
                    0: r.out_red = 8'(v / 257);
                    1: r.out_green = 8'(v / 257);
                    default: r.out_blue = 8'(v / 257);
                endcase
            end
        end
        cnt = (opa_cnt > NPTS) ? NPTS : int'(opa_cnt);
        if (cnt > 0) begin
            k = find_slot(opa_pos, cnt, p, ip);
            v = ip ? lerp(opa_pos[k-1], opa_pos[k], opa_val[k-1], opa_val[k], p)
                   : opa_val[k];
            r.out_alpha = 8'(v / 257);
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end
    assign o_pending = expected_colors.size();

    always @(posedge i_clk) begin
        pltf_pkg::t_out_word got, want;
        pltf_pkg::t_in_word w;
        if (!i_rst_n) begin
            for (int i = 0; i < NPTS; i++) begin
                col_pos[i] = '0; opa_pos[i] = '0; opa_val[i] = '0;
                for (int c = 0; c < 3; c++) col_val[i][c] = '0;
            end
            col_pos[0] = 0;     col_val[0] = '{16'h0000, 16'h0000, 16'hffff};
            col_pos[1] = 16384; col_val[1] = '{16'h0000, 16'hffff, 16'hffff};
            col_pos[2] = 32768; col_val[2] = '{16'h0000, 16'hffff, 16'h0000};
            col_pos[3] = 49151; col_val[3] = '{16'hffff, 16'hffff, 16'h0000};
            col_pos[4] = 65535; col_val[4] = '{16'hffff, 16'h0000, 16'h0000};
            opa_pos[1] = 16'hffff; opa_val[1] = 16'hffff;
            col_cnt = 4'd5;
            opa_cnt = 4'd2;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'(pltf_pkg::REG_COLOR_COUNT) * 4) col_cnt = pwdata[3:0];
                else if (paddr == 3'(pltf_pkg::REG_OPACITY_COUNT) * 4)
                    opa_cnt = pwdata[3:0];
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                got = i_mon_out.data;
                o_result_count++;
                if (expected_colors.size() == 0) begin
                    report("unexpected result word", int'(got), 0);
                end else begin
                    want = expected_colors.pop_front();
                    if (got.out_red != want.out_red) report("red", got.out_red, want.out_red);
                    if (got.out_green != want.out_green)
                        report("green", got.out_green, want.out_green);
                    if (got.out_blue != want.out_blue)
                        report("blue", got.out_blue, want.out_blue);
                    if (got.out_alpha != want.out_alpha)
                        report("alpha", got.out_alpha, want.out_alpha);
                end
            end
            if (i_mon_in.valid && i_mon_in.ready) begin
                w = i_mon_in.data;
                case (pltf_pkg::t_action'(w.action))
                    pltf_pkg::ACT_LOAD_COLOR: begin
                        col_pos[w.point_index] = w.point_position;
                        col_val[w.point_index] = '{w.value_red, w.value_green, w.value_blue};
                    end
                    pltf_pkg::ACT_LOAD_OPACITY: begin
                        opa_pos[w.point_index] = w.point_position;
                        opa_val[w.point_index] = w.value_opacity;
                    end
                    pltf_pkg::ACT_EVALUATE:
                        expected_colors = {expected_colors, shade(w.sample_position)};
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: transfer function unit testbench
// Loads control points, evaluates samples under directed and random stimulus
// with random stalls on both channels, and sweeps both point counts.
// ----------------------------------------------------------------------------
module tb;

    localparam int  LIMIT    = 1500000;
    localparam int  DRAIN    = 300;     // about one evaluate plus margin
    localparam int  PHASES   = 6;
    localparam int  PER_PHASE = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, result_count;
    int          sender_idle, receiver_idle;  // percent
    int          cycles;
    int          evals_sent, loads_sent;

    pltf_in_if  in_ch ();
    pltf_out_if out_ch ();

    piecewise_linear_transfer_function_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pltf_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mon_in       (in_ch),
        .i_mon_out      (out_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Timeout watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("[piecewise_linear_transfer_function_unit] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure per current idle percentage.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= receiver_idle);
    end

    // APB write: setup then access cycle.
    task automatic reg_write(input logic [3:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Wait for outstanding results, then let the last word finish.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Drives one word and holds it until accepted; random idle gap first.
    // valid stays high after acceptance until the next idle gap or settle.
    task automatic send(input pltf_pkg::t_in_word w);
        while ($urandom_range(99) < sender_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (pltf_pkg::t_action'(w.action) == pltf_pkg::ACT_EVALUATE) evals_sent++;
        else loads_sent++;
    endtask

    function automatic pltf_pkg::t_in_word rand_word();
        pltf_pkg::t_in_word w;
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        w = bits[$bits(pltf_pkg::t_in_word)-1:0];
        return w;
    endfunction

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Rewrites a sorted table of n points with random content.
    task automatic load_sorted(input pltf_pkg::t_action act, input int n);
        pltf_pkg::t_in_word w;
        logic [15:0] p;
        p = 16'($urandom_range(2000));
        for (int i = 0; i < n; i++) begin
            w = rand_word();
            w.action = act;
            w.point_index = 3'(i);
            w.point_position = p;
            send(w);
            // Occasional zero-length span.
            if ($urandom_range(7) != 0) p = 16'(int'(p) + $urandom_range(65535 / (n + 1)));
        end
    endtask

    task automatic eval_at(input logic [15:0] p);
        pltf_pkg::t_in_word w;
        w = rand_word();
        w.action = pltf_pkg::ACT_EVALUATE;
        w.sample_position = p;
        send(w);
    endtask

    initial begin
        pltf_pkg::t_in_word w;
        int r;
        int counts [PHASES][2];
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        sender_idle = 16; receiver_idle = 59;
        evals_sent = 0; loads_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default ramps at ends and knots, then edge cases.
        eval_at(16'h0000); eval_at(16'hffff); eval_at(16'd16384);
        eval_at(16'd8192); eval_at(16'd49151); eval_at(16'd40000);
        w = '0; w.action = pltf_pkg::ACT_NONE; send(w);
        w = '0; w.action = pltf_pkg::ACT_LOAD_OPACITY; w.point_index = 3'd1;
        w.point_position = 16'h0000; w.value_opacity = 16'hffff; send(w);  // zero span
        eval_at(16'h0000); eval_at(16'h1234);
        w = '1; w.action = pltf_pkg::ACT_LOAD_COLOR; w.point_index = 3'd7; send(w);
        w = '0; w.action = pltf_pkg::ACT_LOAD_COLOR; w.point_index = 3'd2;
        w.point_position = 16'd1000; send(w);                              // unsorted
        eval_at(16'd20000); eval_at(16'd30000);
        settle();
        reg_write(pltf_pkg::REG_COLOR_COUNT, 32'd0);
        reg_write(pltf_pkg::REG_OPACITY_COUNT, 32'd15);                    // above max
        eval_at(16'd5000); eval_at(16'hffff);
        settle();
        reg_write(pltf_pkg::REG_COLOR_COUNT, 32'd8);
        reg_write(pltf_pkg::REG_OPACITY_COUNT, 32'd0);
        eval_at(16'd100); eval_at(16'd65000);
        settle();

        // Random phases with different count settings and idling profiles.
        counts = '{'{1, 8}, '{8, 1}, '{3, 5}, '{8, 8}, '{15, 0}, '{2, 7}};
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin sender_idle = 59; receiver_idle = 16; end
            if (ph == 4) begin sender_idle = 0; receiver_idle = 0; end
            reg_write(pltf_pkg::REG_COLOR_COUNT, 32'(counts[ph][0]));
            reg_write(pltf_pkg::REG_OPACITY_COUNT, 32'(counts[ph][1]));
            load_sorted(pltf_pkg::ACT_LOAD_COLOR, 8);
            load_sorted(pltf_pkg::ACT_LOAD_OPACITY, 8);
            for (int k = 0; k < PER_PHASE - 16; k++) begin
                r = $urandom_range(99);
                if (r < 80) eval_at(rand_pos());
                else if (r < 90) begin
                    w = rand_word();
                    w.action = ($urandom_range(1) != 0) ? pltf_pkg::ACT_LOAD_COLOR
                                                        : pltf_pkg::ACT_LOAD_OPACITY;
                    send(w);
                end else if (r < 95) begin
                    w = rand_word(); w.action = pltf_pkg::ACT_NONE; send(w);
                end else begin
                    w = rand_word(); send(w);
                end
            end
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("covered %0d evaluates and %0d other words, %0d results checked",
                 evals_sent, loads_sent, result_count);
        $display("point counts swept from empty to above the table size");
        if (fail_count == 0) $display("[piecewise_linear_transfer_function_unit] OK");
        else $display("[piecewise_linear_transfer_function_unit] ERROR");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/pltf_pkg.sv
hw/rtl/pltf_in_if.sv
hw/rtl/pltf_out_if.sv
hw/rtl/piecewise_linear_transfer_function_unit.sv
tb/pltf_checker.sv
tb/tb.sv
